// ===== hdl/iaet_pkg.sv =====
// ----------------------------------------------------------------------------
// iaet_pkg: shared types and constants of the idle-age eviction table
// ----------------------------------------------------------------------------
package iaet_pkg;

  localparam int unsigned EntriesDef = 16;
  localparam int unsigned NumRegs    = 7;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 32;

  typedef enum logic [2:0] {
    CMD_CREATE  = 3'd0,
    CMD_DESTROY = 3'd1,
    CMD_LOAD    = 3'd2,
    CMD_UNLOAD  = 3'd3,
    CMD_LOCK    = 3'd4,
    CMD_UNLOCK  = 3'd5,
    CMD_FRAME   = 3'd6,
    CMD_NOP     = 3'd7
  } cmd_e;

  localparam logic [1:0] ACT_NONE   = 2'd0;
  localparam logic [1:0] ACT_LOAD   = 2'd1;
  localparam logic [1:0] ACT_UNLOAD = 2'd2;

  localparam logic [1:0] MODE_UNLOADED = 2'd0;
  localparam logic [1:0] MODE_LOADED   = 2'd1;
  localparam logic [1:0] MODE_LOCKED   = 2'd2;

  localparam logic [1:0] GC_NONE   = 2'd0;
  localparam logic [1:0] GC_CHECK  = 2'd1;
  localparam logic [1:0] GC_NORMAL = 2'd2;
  localparam logic [1:0] GC_ALERT  = 2'd3;

  localparam logic [1:0] ERR_OK     = 2'd0;
  localparam logic [1:0] ERR_UNUSED = 2'd1;
  localparam logic [1:0] ERR_INUSE  = 2'd2;

  localparam logic [2:0] REG_CHECK_INT  = 3'd0;
  localparam logic [2:0] REG_NORMAL_INT = 3'd1;
  localparam logic [2:0] REG_NORMAL_AGE = 3'd2;
  localparam logic [2:0] REG_ALERT_AGE  = 3'd3;
  localparam logic [2:0] REG_ALERT_MAX  = 3'd4;
  localparam logic [2:0] REG_SYS_LIMIT  = 3'd5;
  localparam logic [2:0] REG_TEX_LIMIT  = 3'd6;

  typedef struct packed {
    logic [2:0]  command;
    logic [3:0]  entry_index;
    logic [31:0] now;
    logic [6:0]  sysmem_load;
    logic [15:0] texmem_free;
  } cmd_t;

  typedef struct packed {
    logic [3:0] result_index;
    logic [1:0] action;
    logic [1:0] entry_status;
    logic [7:0] locks_held;
    logic [1:0] gc_mode;
    logic [1:0] error_code;
    logic       last;
  } res_t;

  // classified item handed from front to back
  typedef struct packed {
    cmd_e        cmd;
    logic [3:0]  idx;
    logic [31:0] now;
    logic        run_check;
    logic        alert;
    logic        collect;
  } job_t;

  typedef struct packed {
    logic [31:0] check_interval;
    logic [31:0] normal_interval;
    logic [31:0] normal_age;
    logic [31:0] alert_age;
    logic [4:0]  alert_max_count;
    logic [6:0]  sysmem_load_limit;
    logic [15:0] texmem_free_limit;
  } cfg_t;

  function automatic logic tick_before(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = b - a;
    return (d != 32'd0) && !d[31];
  endfunction

endpackage

// ===== hdl/iaet_if.sv =====
// ----------------------------------------------------------------------------
// iaet_if: valid/ready channel carrying one payload
// ----------------------------------------------------------------------------
interface iaet_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/iaet_front.sv =====
// ----------------------------------------------------------------------------
// iaet_front: accepts items, runs the frame timing checks, feeds the job queue
// ----------------------------------------------------------------------------
module iaet_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  iaet_pkg::cmd_t      cmd_i,
  input  logic                cmd_valid_i,
  output logic                cmd_ready_o,
  input  iaet_pkg::cfg_t      cfg_i,
  output iaet_pkg::job_t      job_o,
  output logic                job_valid_o,
  input  logic                job_ready_i
);
  import iaet_pkg::*;

  logic [31:0] last_check_q, last_check_d;
  logic [31:0] last_collect_q, last_collect_d;
  logic        run_check, alert, collect;
  job_t        job_d;

  assign cmd_ready_o = job_ready_i;
  assign job_valid_o = cmd_valid_i;

  always_comb begin
    run_check = (cmd_i.command == CMD_FRAME) &&
                tick_before(last_check_q + cfg_i.check_interval, cmd_i.now);
    alert = (cmd_i.sysmem_load > cfg_i.sysmem_load_limit) ||
            (cmd_i.texmem_free < cfg_i.texmem_free_limit);
    collect = alert || tick_before(last_collect_q + cfg_i.normal_interval, cmd_i.now);
    last_check_d   = last_check_q;
    last_collect_d = last_collect_q;
    if (run_check) begin
      last_check_d = cmd_i.now;
      if (collect) begin
        last_collect_d = cmd_i.now;
      end
    end
    job_d.cmd       = cmd_e'(cmd_i.command);
    job_d.idx       = cmd_i.entry_index;
    job_d.now       = cmd_i.now;
    job_d.run_check = run_check;
    job_d.alert     = alert;
    job_d.collect   = collect;
  end

  assign job_o = job_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_check_q   <= '0;
      last_collect_q <= '0;
    end else if (cmd_valid_i && job_ready_i) begin
      last_check_q   <= last_check_d;
      last_collect_q <= last_collect_d;
    end
  end
endmodule

// ===== hdl/iaet_queue.sv =====
// ----------------------------------------------------------------------------
// iaet_queue: two-entry job queue between front and back
// ----------------------------------------------------------------------------
module iaet_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  iaet_pkg::job_t in_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output iaet_pkg::job_t out_o,
  output logic           out_valid_o,
  input  logic           out_ready_i
);
  import iaet_pkg::*;

  job_t       mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_o       = mem_q[rptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= in_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !push) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd0 |-> !pop) else $error("queue underflow");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");
`endif
endmodule

// ===== hdl/iaet_back.sv =====
// ----------------------------------------------------------------------------
// iaet_back: entry table, command execution and collection sweeps
// ----------------------------------------------------------------------------
module iaet_back #(
  parameter int unsigned Entries = iaet_pkg::EntriesDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  iaet_pkg::job_t job_i,
  input  logic           job_valid_i,
  output logic           job_ready_o,
  input  iaet_pkg::cfg_t cfg_i,
  output iaet_pkg::res_t res_o,
  output logic           res_valid_o,
  input  logic           res_ready_i
);
  import iaet_pkg::*;

  localparam int unsigned IdxW = $clog2(Entries);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_PICK,
    ST_EMIT,
    ST_OUT
  } state_e;

  state_e          state_q;
  logic [Entries-1:0] in_use_q, cand_q;
  logic [1:0]      mode_q  [Entries];
  logic [7:0]      locks_q [Entries];
  logic [31:0]     luse_q  [Entries];
  job_t            job_q;
  logic [IdxW-1:0] scan_q;
  logic [IdxW-1:0] best_q;
  logic            best_ok_q;
  logic [31:0]     bage_q;
  logic [4:0]      picked_q;
  logic            pend_q;
  res_t            pend_res_q;
  res_t            res_q;
  logic            res_valid_q;

  logic            in_range;
  logic [IdxW-1:0] ji;
  logic            live;
  logic [31:0]     scan_age;
  logic            scan_loaded;
  logic            out_free;
  logic            sweeping;
  logic            norm_hit;
  logic            alert_hit;
  logic            sweep_go;
  logic            emit_go;
  logic [IdxW-1:0] ev_idx;
  res_t            evict_res;
  res_t            fin_res;
  logic            res_load;

  assign ji          = IdxW'(job_i.idx);
  assign in_range    = ({28'd0, job_i.idx} < 32'(Entries));
  assign live        = in_range && in_use_q[ji];
  assign scan_age    = job_q.now - luse_q[scan_q];
  assign scan_loaded = in_use_q[scan_q] && (mode_q[scan_q] == MODE_LOADED);
  assign out_free    = !res_valid_q || res_ready_i;
  assign job_ready_o = (state_q == ST_IDLE) && out_free;
  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

  assign sweeping  = job_q.run_check && (job_q.alert || job_q.collect);
  assign norm_hit  = scan_loaded &&
                     tick_before(luse_q[scan_q], job_q.now - cfg_i.normal_age);
  assign alert_hit = scan_loaded && job_q.alert &&
                     tick_before(luse_q[scan_q], job_q.now - cfg_i.alert_age);
  // a held eviction leaves once the next one is known, or at the end of the frame
  assign sweep_go  = !(norm_hit && pend_q && !out_free);
  assign emit_go   = !pend_q || out_free;
  assign ev_idx    = (state_q == ST_EMIT) ? best_q : scan_q;

  always_comb begin
    evict_res              = '0;
    evict_res.result_index = 4'(ev_idx);
    evict_res.action       = ACT_UNLOAD;
    evict_res.entry_status = MODE_UNLOADED;
    evict_res.locks_held   = locks_q[ev_idx];
    evict_res.gc_mode      = job_q.alert ? GC_ALERT : GC_NORMAL;
    evict_res.error_code   = ERR_OK;
    evict_res.last         = 1'b0;
  end

  always_comb begin
    fin_res      = pend_res_q;
    fin_res.last = 1'b1;
    if (!pend_q) begin
      fin_res              = '0;
      fin_res.result_index = '0;
      fin_res.action       = ACT_NONE;
      fin_res.entry_status = MODE_UNLOADED;
      fin_res.locks_held   = '0;
      fin_res.gc_mode      = !job_q.run_check ? GC_NONE :
                             job_q.alert ? GC_ALERT :
                             job_q.collect ? GC_NORMAL : GC_CHECK;
      fin_res.error_code   = ERR_OK;
      fin_res.last         = 1'b1;
    end
  end

  always_comb begin
    case (state_q)
      ST_IDLE:  res_load = job_valid_i && job_ready_o && (job_i.cmd != CMD_FRAME);
      ST_SWEEP: res_load = sweeping && norm_hit && pend_q && out_free;
      ST_EMIT:  res_load = best_ok_q && pend_q && out_free;
      ST_OUT:   res_load = out_free;
      default:  res_load = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && job_valid_i && job_ready_o && job_i.cmd != CMD_FRAME &&
        live && (job_i.cmd == CMD_LOAD || job_i.cmd == CMD_LOCK ||
                 job_i.cmd == CMD_UNLOCK)) begin
      luse_q[ji] <= job_i.now;
    end else if (state_q == ST_IDLE && job_valid_i && job_ready_o &&
                 job_i.cmd == CMD_CREATE && in_range && !in_use_q[ji]) begin
      luse_q[ji] <= job_i.now;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_use_q    <= '0;
      cand_q      <= '0;
      for (int i = 0; i < Entries; i++) begin
        mode_q[i]  <= MODE_UNLOADED;
        locks_q[i] <= '0;
      end
      job_q       <= '0;
      scan_q      <= '0;
      best_q      <= '0;
      best_ok_q   <= 1'b0;
      bage_q      <= '0;
      picked_q    <= '0;
      pend_q      <= 1'b0;
      pend_res_q  <= '0;
      res_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_load || (res_valid_q && !res_ready_i);
      unique case (state_q)
        ST_IDLE: begin
          if (job_valid_i && job_ready_o) begin
            job_q <= job_i;
            if (job_i.cmd == CMD_FRAME) begin
              scan_q   <= '0;
              cand_q   <= '0;
              picked_q <= '0;
              state_q  <= ST_SWEEP;
            end else begin
              logic [1:0] act, err, md;
              logic [7:0] lk;
              act = ACT_NONE;
              err = ERR_OK;
              md  = in_range ? mode_q[ji] : MODE_UNLOADED;
              lk  = in_range ? locks_q[ji] : 8'd0;
              case (job_i.cmd)
                CMD_CREATE: begin
                  if (live) err = ERR_INUSE;
                  else if (!in_range) err = ERR_UNUSED;
                  else begin
                    in_use_q[ji] <= 1'b1;
                    md = MODE_UNLOADED;
                    lk = 8'd0;
                  end
                end
                CMD_DESTROY, CMD_LOAD, CMD_UNLOAD, CMD_LOCK, CMD_UNLOCK: begin
                  if (!live) err = ERR_UNUSED;
                  else begin
                    case (job_i.cmd)
                      CMD_DESTROY: begin
                        in_use_q[ji] <= 1'b0;
                        md = MODE_UNLOADED;
                        lk = 8'd0;
                      end
                      CMD_LOAD: begin
                        if (md == MODE_UNLOADED) begin
                          md  = MODE_LOADED;
                          act = ACT_LOAD;
                        end
                      end
                      CMD_UNLOAD: begin
                        if (md == MODE_LOADED) begin
                          md  = MODE_UNLOADED;
                          act = ACT_UNLOAD;
                        end
                      end
                      CMD_LOCK: begin
                        if (md == MODE_UNLOADED) act = ACT_LOAD;
                        md = MODE_LOCKED;
                        if (lk != 8'hff) lk = lk + 8'd1;
                      end
                      default: begin
                        if (md == MODE_LOCKED) begin
                          if (lk != 8'd0) lk = lk - 8'd1;
                          if (lk == 8'd0) md = MODE_LOADED;
                        end
                      end
                    endcase
                  end
                end
                default: ;
              endcase
              if (in_range) begin
                mode_q[ji]  <= md;
                locks_q[ji] <= lk;
              end
              res_q.result_index <= job_i.idx;
              res_q.action       <= act;
              res_q.entry_status <= md;
              res_q.locks_held   <= lk;
              res_q.gc_mode      <= GC_NONE;
              res_q.error_code   <= err;
              res_q.last         <= 1'b1;
            end
          end
        end
        ST_SWEEP: begin
          if (!sweeping) begin
            state_q <= ST_OUT;
          end else if (sweep_go) begin
            if (norm_hit) begin
              mode_q[scan_q] <= MODE_UNLOADED;
              if (pend_q) res_q <= pend_res_q;
              pend_res_q <= evict_res;
              pend_q     <= 1'b1;
            end else if (alert_hit) begin
              cand_q[scan_q] <= 1'b1;
            end
            if (32'(scan_q) == Entries - 1) begin
              scan_q    <= '0;
              best_ok_q <= 1'b0;
              state_q   <= job_q.alert ? ST_PICK : ST_OUT;
            end else begin
              scan_q <= scan_q + IdxW'(1);
            end
          end
        end
        ST_PICK: begin
          if (picked_q >= cfg_i.alert_max_count) begin
            state_q <= ST_OUT;
          end else begin
            if (cand_q[scan_q] && (!best_ok_q || scan_age > bage_q)) begin
              best_q    <= scan_q;
              bage_q    <= scan_age;
              best_ok_q <= 1'b1;
            end
            if (32'(scan_q) == Entries - 1) begin
              scan_q  <= '0;
              state_q <= ST_EMIT;
            end else begin
              scan_q <= scan_q + IdxW'(1);
            end
          end
        end
        ST_EMIT: begin
          if (!best_ok_q) begin
            state_q <= ST_OUT;
          end else if (emit_go) begin
            cand_q[best_q] <= 1'b0;
            mode_q[best_q] <= MODE_UNLOADED;
            if (pend_q) res_q <= pend_res_q;
            pend_res_q <= evict_res;
            pend_q     <= 1'b1;
            picked_q   <= picked_q + 5'd1;
            best_ok_q  <= 1'b0;
            state_q    <= ST_PICK;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            res_q   <= fin_res;
            pend_q  <= 1'b0;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_one_hot_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !res_ready_i |=> res_valid_q) else $error("result dropped");
  a_pend_only_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> state_q != ST_IDLE) else $error("pending result while idle");
  a_pick_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    picked_q <= 5'd16) else $error("too many alert evictions");
`endif
endmodule

// ===== hdl/idle_age_eviction_table_top.sv =====
// ----------------------------------------------------------------------------
// idle_age_eviction_table_top: idle-age eviction table
// An entry command returns its one result via the job queue register and the
// result register when the back end is free. A frame check walks the table one
// entry a cycle while the output is not stalled: a sweep over all ENTRIES, then
// in alert collection one pass over the table for each age-ordered eviction and
// one more pass when fewer than alert_max_count entries qualify, with the scans
// done by the single scan unit; a stalled output stretches this. The job queue
// takes up to two more items while a frame runs.
// ----------------------------------------------------------------------------
module idle_age_eviction_table_top #(
  parameter int unsigned Entries = iaet_pkg::EntriesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  iaet_if.sink                          in_if,
  iaet_if.source                        out_if,
  input  logic                          cfg_we_i,
  input  logic [iaet_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [iaet_pkg::CfgDataW-1:0] cfg_data_i
);
  import iaet_pkg::*;

  cfg_t cfg_q;
  job_t fr_job, q_out;
  logic fr_valid, fr_ready, q_valid, q_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.check_interval    <= 32'd3000;
      cfg_q.normal_interval   <= 32'd60000;
      cfg_q.normal_age        <= 32'd120000;
      cfg_q.alert_age         <= 32'd3000;
      cfg_q.alert_max_count   <= 5'd10;
      cfg_q.sysmem_load_limit <= 7'd90;
      cfg_q.texmem_free_limit <= 16'd2;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CHECK_INT:  cfg_q.check_interval    <= cfg_data_i;
        REG_NORMAL_INT: cfg_q.normal_interval   <= cfg_data_i;
        REG_NORMAL_AGE: cfg_q.normal_age        <= cfg_data_i;
        REG_ALERT_AGE:  cfg_q.alert_age         <= cfg_data_i;
        REG_ALERT_MAX:  cfg_q.alert_max_count   <= cfg_data_i[4:0];
        REG_SYS_LIMIT:  cfg_q.sysmem_load_limit <= cfg_data_i[6:0];
        REG_TEX_LIMIT:  cfg_q.texmem_free_limit <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  iaet_front u_front (
    .clk_i, .rst_ni,
    .cmd_i(in_if.data), .cmd_valid_i(in_if.valid), .cmd_ready_o(in_if.ready),
    .cfg_i(cfg_q), .job_o(fr_job), .job_valid_o(fr_valid), .job_ready_i(fr_ready)
  );

  iaet_queue u_queue (
    .clk_i, .rst_ni,
    .in_i(fr_job), .in_valid_i(fr_valid), .in_ready_o(fr_ready),
    .out_o(q_out), .out_valid_o(q_valid), .out_ready_i(q_ready)
  );

  iaet_back #(.Entries(Entries)) u_back (
    .clk_i, .rst_ni,
    .job_i(q_out), .job_valid_i(q_valid), .job_ready_o(q_ready),
    .cfg_i(cfg_q), .res_o(out_if.data), .res_valid_o(out_if.valid),
    .res_ready_i(out_if.ready)
  );
endmodule

// ===== dv/idle_age_eviction_table_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idle_age_eviction_table_top_test: self-checking bench for the eviction table
// Drives entry commands and frame checks with random idling on both channels.
// A scoreboard class tracks the table state, predicts every result and
// compares each output transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module idle_age_eviction_table_top_test;
  import iaet_pkg::*;

  localparam int unsigned NEnt = 16;

  class evict_scoreboard;
    bit          in_use [NEnt];
    logic [1:0]  mode [NEnt];
    logic [7:0]  depth [NEnt];
    logic [31:0] used_at [NEnt];
    logic [31:0] checked_at, collected_at;
    cfg_t        cfg;
    res_t        pending[$];
    int          errors;

    function new();
      errors = 0;
      checked_at = 0;
      collected_at = 0;
      cfg.check_interval = 3000;
      cfg.normal_interval = 60000;
      cfg.normal_age = 120000;
      cfg.alert_age = 3000;
      cfg.alert_max_count = 10;
      cfg.sysmem_load_limit = 90;
      cfg.texmem_free_limit = 2;
      for (int i = 0; i < NEnt; i++) begin
        in_use[i] = 0;
        mode[i] = MODE_UNLOADED;
        depth[i] = 0;
        used_at[i] = 0;
      end
    endfunction

    function bit earlier(logic [31:0] a, logic [31:0] b);
      logic [31:0] d;
      d = b - a;
      return d != 0 && !d[31];
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        REG_CHECK_INT:  cfg.check_interval = v;
        REG_NORMAL_INT: cfg.normal_interval = v;
        REG_NORMAL_AGE: cfg.normal_age = v;
        REG_ALERT_AGE:  cfg.alert_age = v;
        REG_ALERT_MAX:  cfg.alert_max_count = v[4:0];
        REG_SYS_LIMIT:  cfg.sysmem_load_limit = v[6:0];
        REG_TEX_LIMIT:  cfg.texmem_free_limit = v[15:0];
        default: ;
      endcase
    endfunction

    function res_t evicted(int i, logic [1:0] gc);
      res_t r;
      r = '0;
      r.result_index = 4'(i);
      r.action = ACT_UNLOAD;
      r.entry_status = mode[i];
      r.locks_held = depth[i];
      r.gc_mode = gc;
      return r;
    endfunction

    function void note_transfer(cmd_t c);
      res_t r;
      res_t batch[$];
      logic [1:0] gc;
      bit alert;
      bit cand [NEnt];
      logic [31:0] nold, aold, bage, age;
      int best, i;
      r = '0;
      if (c.command == CMD_FRAME) begin
        gc = GC_NONE;
        if (earlier(checked_at + cfg.check_interval, c.now)) begin
          alert = c.sysmem_load > cfg.sysmem_load_limit ||
                  c.texmem_free < cfg.texmem_free_limit;
          gc = GC_CHECK;
          if (alert) gc = GC_ALERT;
          else if (earlier(collected_at + cfg.normal_interval, c.now)) gc = GC_NORMAL;
          if (gc >= GC_NORMAL) begin
            nold = c.now - cfg.normal_age;
            aold = c.now - cfg.alert_age;
            for (i = 0; i < NEnt; i++) begin
              cand[i] = 0;
              if (in_use[i] && mode[i] == MODE_LOADED) begin
                if (earlier(used_at[i], nold)) begin
                  mode[i] = MODE_UNLOADED;
                  batch = {batch, evicted(i, gc)};
                end else if (alert && earlier(used_at[i], aold)) begin
                  cand[i] = 1;
                end
              end
            end
            for (int p = 0; alert && p < cfg.alert_max_count; p++) begin
              best = -1;
              bage = 0;
              for (i = 0; i < NEnt; i++) begin
                age = c.now - used_at[i];
                if (cand[i] && (best < 0 || age > bage)) begin
                  best = i;
                  bage = age;
                end
              end
              if (best < 0) break;
              cand[best] = 0;
              mode[best] = MODE_UNLOADED;
              batch = {batch, evicted(best, gc)};
            end
            collected_at = c.now;
          end
          checked_at = c.now;
        end
        if (batch.size() == 0) begin
          r.gc_mode = gc;
          batch = {batch, r};
        end
        batch[batch.size()-1].last = 1;
        pending = {pending, batch};
        return;
      end
      i = c.entry_index;
      r.action = ACT_NONE;
      r.error_code = ERR_OK;
      case (c.command)
        CMD_CREATE: begin
          if (in_use[i]) r.error_code = ERR_INUSE;
          else begin
            in_use[i] = 1;
            mode[i] = MODE_UNLOADED;
            depth[i] = 0;
            used_at[i] = c.now;
          end
        end
        CMD_NOP: ;
        default: begin
          if (!in_use[i]) r.error_code = ERR_UNUSED;
          else case (c.command)
            CMD_DESTROY: begin
              in_use[i] = 0;
              mode[i] = MODE_UNLOADED;
              depth[i] = 0;
            end
            CMD_LOAD: begin
              if (mode[i] == MODE_UNLOADED) begin
                mode[i] = MODE_LOADED;
                r.action = ACT_LOAD;
              end
              used_at[i] = c.now;
            end
            CMD_UNLOAD: begin
              if (mode[i] == MODE_LOADED) begin
                mode[i] = MODE_UNLOADED;
                r.action = ACT_UNLOAD;
              end
            end
            CMD_LOCK: begin
              if (mode[i] == MODE_UNLOADED) r.action = ACT_LOAD;
              mode[i] = MODE_LOCKED;
              if (depth[i] != 8'hff) depth[i]++;
              used_at[i] = c.now;
            end
            default: begin
              if (mode[i] == MODE_LOCKED) begin
                if (depth[i] != 0) depth[i]--;
                if (depth[i] == 0) mode[i] = MODE_LOADED;
              end
              used_at[i] = c.now;
            end
          endcase
        end
      endcase
      r.result_index = 4'(i);
      r.entry_status = mode[i];
      r.locks_held = depth[i];
      r.last = 1;
      pending = {pending, r};
    endfunction

    task report(string what);
      $display("error: %s", what);
      errors++;
    endtask

    task check_result(res_t got);
      res_t w;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result %p", got));
        return;
      end
      w = pending.pop_front();
      if (got.result_index !== w.result_index) report("result_index");
      if (got.action !== w.action) report("action");
      if (got.entry_status !== w.entry_status) report("entry_status");
      if (got.locks_held !== w.locks_held) report("locks_held");
      if (got.gc_mode !== w.gc_mode) report("gc_mode");
      if (got.error_code !== w.error_code) report("error_code");
      if (got.last !== w.last) report("last");
    endtask
  endclass

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  iaet_if #(.T(cmd_t)) in_if ();
  iaet_if #(.T(res_t)) out_if ();

  idle_age_eviction_table_top DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_if(in_if.sink), .out_if(out_if.source),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  evict_scoreboard sb = new();
  int unsigned cycles;
  bit calm;
  logic [31:0] clock_now;
  bit [NEnt-1:0] made;

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("idle_age_eviction_table_top: mismatch");
      $finish;
    end
  end

  // output side: random stall, checked at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) sb.check_result(out_if.data);
  end
  always @(negedge clk_i) begin
    out_if.ready <= calm || ($urandom_range(99) >= 17);
  end

  task send(cmd_t c);
    while (!calm && $urandom_range(99) < 17) begin
      in_if.valid <= 0;
      @(negedge clk_i);
    end
    in_if.data <= c;
    in_if.valid <= 1;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_transfer(c);
    @(negedge clk_i);
  endtask

  task op(cmd_e k, int idx, int step, int sys = 50, int tex = 1000);
    cmd_t c;
    clock_now = clock_now + 32'(step);
    c.command = k;
    c.entry_index = 4'(idx);
    c.now = clock_now;
    c.sysmem_load = 7'(sys);
    c.texmem_free = 16'(tex);
    send(c);
  endtask

  task drain();
    in_if.valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (600) @(negedge clk_i);
  endtask

  task write_reg(logic [2:0] idx, logic [31:0] v);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 0;
    sb.set_reg(idx, v);
    @(negedge clk_i);
  endtask

  task random_item();
    cmd_t c;
    int r;
    r = $urandom_range(99);
    c.entry_index = 4'($urandom);
    if (r < 12) c.command = CMD_FRAME;
    else if (r < 14) c.command = CMD_NOP;
    else c.command = cmd_e'($urandom_range(5));
    if (c.command != CMD_CREATE && !made[c.entry_index] && $urandom_range(3) != 0)
      c.command = CMD_CREATE;
    if (c.command == CMD_CREATE) made[c.entry_index] = 1;
    if ($urandom_range(49) == 0) clock_now = $urandom;
    else clock_now += $urandom_range(2000);
    c.now = clock_now;
    c.sysmem_load = $urandom_range(3) == 0 ? 7'($urandom) : 7'($urandom_range(100));
    c.texmem_free = $urandom_range(3) == 0 ? 16'($urandom_range(4)) : 16'($urandom);
    send(c);
  endtask

  initial begin
    cycles = 0;
    calm = 0;
    clock_now = 0;
    made = '0;
    rst_ni = 0;
    cfg_we_i = 0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_if.valid = 0;
    in_if.data = '0;
    out_if.ready = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // directed part on reset settings
    op(CMD_LOAD, 3, 1);
    op(CMD_CREATE, 3, 1);
    op(CMD_CREATE, 3, 1);
    op(CMD_CREATE, 15, 1);
    op(CMD_CREATE, 0, 1);
    op(CMD_LOAD, 3, 1);
    op(CMD_LOAD, 3, 1);
    op(CMD_LOCK, 15, 1);
    op(CMD_LOCK, 3, 1);
    op(CMD_UNLOCK, 3, 1);
    op(CMD_UNLOAD, 3, 1);
    op(CMD_LOAD, 0, 1);
    op(CMD_NOP, 9, 1);
    op(CMD_DESTROY, 15, 1);
    op(CMD_DESTROY, 15, 1);
    op(CMD_LOAD, 3, 1);
    op(CMD_FRAME, 0, 10);
    op(CMD_FRAME, 0, 4000, 100, 65535);
    op(CMD_FRAME, 0, 4000, 50, 0);
    op(CMD_FRAME, 0, 200000);
    made[0] = 1;
    made[3] = 1;
    made[15] = 1;
    op(CMD_CREATE, 7, 1);
    for (int i = 0; i < 18; i++) op(CMD_LOCK, 7, 0);
    made[7] = 1;
    drain();

    write_reg(REG_CHECK_INT, 0);
    write_reg(REG_NORMAL_INT, 0);
    write_reg(REG_NORMAL_AGE, 32'hffff_ffff);
    write_reg(REG_ALERT_AGE, 0);
    write_reg(REG_ALERT_MAX, 16);
    write_reg(REG_SYS_LIMIT, 0);
    write_reg(REG_TEX_LIMIT, 65535);
    for (int i = 0; i < 16; i++) begin
      op(CMD_CREATE, i, 3);
      op(CMD_LOAD, i, 1 + (i % 3));
    end
    op(CMD_FRAME, 0, 1, 100, 0);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      calm = (ph == 1);
      write_reg(REG_CHECK_INT, ph == 2 ? 32'hffff_ffff : $urandom_range(4000));
      write_reg(REG_NORMAL_INT, $urandom_range(8000));
      write_reg(REG_NORMAL_AGE, $urandom_range(30000));
      write_reg(REG_ALERT_AGE, ph == 2 ? 32'h0 : $urandom_range(6000));
      write_reg(REG_ALERT_MAX, ph == 0 ? 0 : $urandom_range(16));
      write_reg(REG_SYS_LIMIT, ph == 2 ? 100 : $urandom_range(100));
      write_reg(REG_TEX_LIMIT, ph == 0 ? 0 : $urandom);
      for (int n = 0; n < 65; n++) random_item();
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("idle_age_eviction_table_top: match");
    end else begin
      $display("idle_age_eviction_table_top: mismatch");
    end
    $finish;
  end
endmodule
